// File: hdl/atms_pkg.sv
// ----------------------------------------------------------------------------
// atms_pkg: shared types and helpers for the triangle midpoint splitter
// Vertex, item and result formats, queue entry, and the edge and midpoint
// arithmetic used by the front and back parts.
// ----------------------------------------------------------------------------
package atms_pkg;

  localparam int COORD_BITS  = 24;              // signed Q.8 coordinate width
  localparam int THRESH_BITS = 48;
  localparam int DIFF_W      = COORD_BITS + 1;  // exact coordinate difference
  localparam int MAG_W       = 25;              // clamped magnitude, up to 2^24
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 2;        // sum of three squares
  localparam longint unsigned DiffClamp = 64'd16777216;
  localparam logic [THRESH_BITS-1:0] ThreshReset = THRESH_BITS'(256);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_item_t;

  typedef struct packed {
    coord_t out_ax;
    coord_t out_ay;
    coord_t out_az;
    coord_t out_bx;
    coord_t out_by;
    coord_t out_bz;
    coord_t out_cx;
    coord_t out_cy;
    coord_t out_cz;
    logic   is_split;
    logic   last_of_run;
  } result_t;

  // Classified triangle handed from front to back
  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic split;
  } entry_t;

  // Queue status seen by the top level and the back part
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic coord_t vtx_axis(vtx_t v, logic [1:0] i);
    coord_t r;
    case (i)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

  // |p - q|, clamped to 2^24
  function automatic logic [MAG_W-1:0] abs_clamp(coord_t p, coord_t q);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [63:0]              m64;
    d   = {p[COORD_BITS-1], p} - {q[COORD_BITS-1], q};
    m   = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    m64 = 64'(m);
    if (m64 > DiffClamp) begin
      m64 = DiffClamp;
    end
    return m64[MAG_W-1:0];
  endfunction

  // (p + q) >>> 1, rounds toward minus infinity
  function automatic coord_t half_sum(coord_t p, coord_t q);
    logic [DIFF_W-1:0] s;
    s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
    return s[DIFF_W-1:1];
  endfunction

  function automatic vtx_t midpoint(vtx_t p, vtx_t q);
    vtx_t m;
    m.x = half_sum(p.x, q.x);
    m.y = half_sum(p.y, q.y);
    m.z = half_sum(p.z, q.z);
    return m;
  endfunction

endpackage

// File: hdl/atms_front.sv
// ----------------------------------------------------------------------------
// atms_front: edge length classifier
// Two-stage pipeline: clamped coordinate differences, then squares; the
// edge sums are compared with the threshold as the entry enters the queue.
// ----------------------------------------------------------------------------
module atms_front import atms_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  in_item_t               in_data_i,
  input  logic [THRESH_BITS-1:0] thresh_i,
  output logic                   ent_valid_o,
  output entry_t                 ent_o
);

  localparam int NumTerms = 9;

  vtx_t va, vb, vc;
  vtx_t pv [3];
  vtx_t qv [3];
  logic [MAG_W-1:0] mag [NumTerms];

  logic             s1_valid_q;
  vtx_t             s1_a_q, s1_b_q, s1_c_q;
  logic [MAG_W-1:0] s1_mag_q [NumTerms];

  logic             s2_valid_q;
  vtx_t             s2_a_q, s2_b_q, s2_c_q;
  logic [SQ_W-1:0]  s2_sq_q [NumTerms];

  logic [SUM_W-1:0] len2 [3];
  logic             all_short;

  always_comb begin
    va = '{x: in_data_i.ax, y: in_data_i.ay, z: in_data_i.az};
    vb = '{x: in_data_i.bx, y: in_data_i.by_coord, z: in_data_i.bz};
    vc = '{x: in_data_i.cx, y: in_data_i.cy, z: in_data_i.cz};
    // edges AB, AC, BC
    pv[0] = va; qv[0] = vb;
    pv[1] = va; qv[1] = vc;
    pv[2] = vb; qv[2] = vc;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        mag[3*e+k] = abs_clamp(vtx_axis(pv[e], 2'(k)), vtx_axis(qv[e], 2'(k)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q <= va;
    s1_b_q <= vb;
    s1_c_q <= vc;
    s2_a_q <= s1_a_q;
    s2_b_q <= s1_b_q;
    s2_c_q <= s1_c_q;
    for (int i = 0; i < NumTerms; i++) begin
      s1_mag_q[i] <= mag[i];
      s2_sq_q[i]  <= s1_mag_q[i] * s1_mag_q[i];
    end
  end

  always_comb begin
    all_short = 1'b1;
    for (int e = 0; e < 3; e++) begin
      len2[e] = SUM_W'(s2_sq_q[3*e]) + SUM_W'(s2_sq_q[3*e+1]) + SUM_W'(s2_sq_q[3*e+2]);
      if (len2[e] >= SUM_W'(thresh_i)) begin
        all_short = 1'b0;
      end
    end
  end

  assign ent_valid_o = s2_valid_q;
  assign ent_o       = '{a: s2_a_q, b: s2_b_q, c: s2_c_q, split: !all_short};

endmodule

// File: hdl/atms_queue.sv
// ----------------------------------------------------------------------------
// atms_queue: entry queue between classifier and expander
// Slots are reserved when an item is accepted, so the classifier pipeline
// never has to stall; full reports that every slot is spoken for.
// ----------------------------------------------------------------------------
module atms_queue import atms_pkg::*; #(
  parameter int QDEPTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    rsv_i,
  input  logic    wr_i,
  input  entry_t  wr_data_i,
  input  logic    rd_i,
  output entry_t  head_o,
  output q_stat_t stat_o
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);

  entry_t            mem_q [QDEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   fill_q, rsv_cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QDEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      fill_q    <= '0;
      rsv_cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      fill_q    <= fill_q + CntW'(wr_i) - CntW'(rd_i);
      rsv_cnt_q <= rsv_cnt_q + CntW'(rsv_i) - CntW'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (fill_q == '0);
  assign stat_o.full  = (rsv_cnt_q == CntW'(QDEPTH));

endmodule

// File: hdl/atms_back.sv
// ----------------------------------------------------------------------------
// atms_back: result expander
// Turns the head entry into one final triangle or four sub-triangles, one
// per cycle while the consumer pops, into a result register that the consumer pops.
// ----------------------------------------------------------------------------
module atms_back import atms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  entry_t  head_i,
  input  q_stat_t q_stat_i,
  output logic    q_rd_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t res_o
);

  localparam logic [1:0] SubFirst = 2'd0;
  localparam logic [1:0] SubLast  = 2'd3;

  logic [1:0] sub_q;
  logic       res_valid_q;
  result_t    res_q;

  vtx_t    m_ab, m_ac, m_bc;
  vtx_t    ra, rb, rc;
  logic    last;
  logic    load;
  result_t res_d;

  always_comb begin
    m_ab = midpoint(head_i.a, head_i.b);
    m_ac = midpoint(head_i.a, head_i.c);
    m_bc = midpoint(head_i.b, head_i.c);
    ra   = head_i.a;
    rb   = head_i.b;
    rc   = head_i.c;
    last = 1'b1;
    if (head_i.split) begin
      last = (sub_q == SubLast);
      case (sub_q)
        2'd0:    begin ra = head_i.a; rb = m_ab;     rc = m_ac;     end
        2'd1:    begin ra = m_ab;     rb = head_i.b; rc = m_bc;     end
        2'd2:    begin ra = m_ac;     rb = m_bc;     rc = head_i.c; end
        default: begin ra = m_ac;     rb = m_ab;     rc = m_bc;     end
      endcase
    end
    res_d = '{out_ax: ra.x, out_ay: ra.y, out_az: ra.z,
              out_bx: rb.x, out_by: rb.y, out_bz: rb.z,
              out_cx: rc.x, out_cy: rc.y, out_cz: rc.z,
              is_split: head_i.split, last_of_run: last};
  end

  // refill the result register when it is empty or being popped
  assign load   = !res_valid_q || pop_i;
  assign q_rd_o = load && !q_stat_i.empty && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= SubFirst;
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        sub_q <= last ? SubFirst : sub_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      res_q <= res_d;
    end
  end

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

endmodule

// File: hdl/adaptive_triangle_midpoint_splitter_unit.sv
// Path: an accepted triangle passes both classifier stages and the queue
// before its first result is loaded into the result register.
// Output: a final triangle gives one result, a split triangle four; the
// result register emits one sub-triangle per cycle while the consumer pops.
// Reset: asynchronous, clears the pipeline, queue and result register;
// thresh_q returns to 256.
// ----------------------------------------------------------------------------
// adaptive_triangle_midpoint_splitter_unit: adaptive midpoint subdivision
// Classifies each triangle by its squared edge lengths and emits it as final
// or as four midpoint sub-triangles.
// ----------------------------------------------------------------------------
module adaptive_triangle_midpoint_splitter_unit import atms_pkg::*; #(
  parameter int QDEPTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_data_i,
  output logic                   empty,
  input  logic                   pop,
  output result_t                res_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [THRESH_BITS-1:0] cfg_data_i
);

  logic [THRESH_BITS-1:0] thresh_q;
  logic                   accept;
  logic                   ent_valid;
  entry_t                 ent;
  entry_t                 head;
  q_stat_t                q_stat;
  logic                   q_rd;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_stat.full;
  assign full        = q_stat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  atms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_data_i   (in_data_i),
    .thresh_i    (thresh_q),
    .ent_valid_o (ent_valid),
    .ent_o       (ent)
  );

  atms_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rsv_i     (accept),
    .wr_i      (ent_valid),
    .wr_data_i (ent),
    .rd_i      (q_rd),
    .head_o    (head),
    .stat_o    (q_stat)
  );

  atms_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .q_rd_o   (q_rd),
    .pop_i    (pop),
    .empty_o  (empty),
    .res_o    (res_data_o)
  );

endmodule

// File: hdl/atms_checker.sv
// ----------------------------------------------------------------------------
// atms_checker: port-level checks for the triangle splitter
// Watches the queue-style ports and the result stream.
// ----------------------------------------------------------------------------
module atms_checker import atms_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t res_data_o
);

  // nothing waits on the result side while in reset
  assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  assert property (@(posedge clk_i) !rst_ni |-> !full)
    else $error("full during reset");

  // a final triangle is always the only result of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty && !res_data_o.is_split |-> res_data_o.last_of_run)
    else $error("final triangle not marked last");

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty && !pop |=> !empty && $stable(res_data_o))
    else $error("stalled result changed");

endmodule

bind adaptive_triangle_midpoint_splitter_unit atms_checker u_chk (.*);

// File: tb/adaptive_triangle_midpoint_splitter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adaptive_triangle_midpoint_splitter_unit_tb: self-checking bench
// Feeds triangles through the push/full queue port and predicts each one
// as final or as four midpoint sub-triangles. Compares every popped result
// field by field. Runs directed corners at the reset threshold, then random
// triangles under zero, full-scale, tiny and random thresholds, with random
// stalls on both sides and a final stretch without stalls.
// ----------------------------------------------------------------------------
module adaptive_triangle_midpoint_splitter_unit_tb;
  import atms_pkg::*;

  localparam int     CYCLE_LIMIT = 200_000;
  localparam coord_t CMIN = coord_t'(-(1 << (COORD_BITS - 1)));
  localparam coord_t CMAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
  localparam logic [THRESH_BITS-1:0] ThreshMax = '1;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   push = 1'b0;
  logic                   full;
  in_item_t               in_data_i = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                res_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [THRESH_BITS-1:0] cfg_data_i = '0;

  in_item_t               tris_to_send[$];
  result_t                expected_tris[$];
  logic [THRESH_BITS-1:0] short_limit = ThreshReset;
  logic                   in_acc = 1'b0;
  bit                     steady = 1'b0;
  int                     tx_gap = 0;
  int                     rx_gap = 0;
  int                     errors = 0;
  int                     cycles = 0;

  adaptive_triangle_midpoint_splitter_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .empty       (empty),
    .pop         (pop),
    .res_data_o  (res_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Squared distance along one axis, magnitude clamped to 2^24
  function automatic logic [63:0] axis_sq(coord_t p, coord_t q);
    longint d;
    d = longint'(p) - longint'(q);
    if (d < 0) begin
      d = -d;
    end
    if (d > 64'sd16777216) begin
      d = 64'sd16777216;
    end
    return 64'(d * d);
  endfunction

  function automatic logic [63:0] edge_len2(vtx_t p, vtx_t q);
    return axis_sq(p.x, q.x) + axis_sq(p.y, q.y) + axis_sq(p.z, q.z);
  endfunction

  function automatic coord_t half_of(coord_t p, coord_t q);
    return coord_t'((longint'(p) + longint'(q)) >>> 1);
  endfunction

  function automatic vtx_t mid_of(vtx_t p, vtx_t q);
    vtx_t m;
    m.x = half_of(p.x, q.x);
    m.y = half_of(p.y, q.y);
    m.z = half_of(p.z, q.z);
    return m;
  endfunction

  function automatic result_t make_tri(vtx_t a, vtx_t b, vtx_t c, logic split, logic last);
    return {a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z, split, last};
  endfunction

  // Append to the pending and expected queues
  task automatic add_item(input in_item_t t);
    tris_to_send.insert(tris_to_send.size(), t);
  endtask

  task automatic add_expected(input result_t r);
    expected_tris.insert(expected_tris.size(), r);
  endtask

  task automatic predict_split(input in_item_t t);
    vtx_t a, b, c, mab, mac, mbc;
    a = {t.ax, t.ay, t.az};
    b = {t.bx, t.by_coord, t.bz};
    c = {t.cx, t.cy, t.cz};
    if (edge_len2(a, b) < short_limit && edge_len2(a, c) < short_limit &&
        edge_len2(b, c) < short_limit) begin
      add_expected(make_tri(a, b, c, 1'b0, 1'b1));
    end else begin
      mab = mid_of(a, b);
      mac = mid_of(a, c);
      mbc = mid_of(b, c);
      add_expected(make_tri(a, mab, mac, 1'b1, 1'b0));
      add_expected(make_tri(mab, b, mbc, 1'b1, 1'b0));
      add_expected(make_tri(mac, mbc, c, 1'b1, 1'b0));
      add_expected(make_tri(mac, mab, mbc, 1'b1, 1'b1));
    end
  endtask

  task automatic check_tri(input result_t got, input result_t want);
    string  names[11] = '{"out_ax", "out_ay", "out_az", "out_bx", "out_by", "out_bz",
                          "out_cx", "out_cy", "out_cz", "is_split", "last_of_run"};
    longint g[11];
    longint w[11];
    g = '{longint'(got.out_ax), longint'(got.out_ay), longint'(got.out_az),
          longint'(got.out_bx), longint'(got.out_by), longint'(got.out_bz),
          longint'(got.out_cx), longint'(got.out_cy), longint'(got.out_cz),
          longint'(got.is_split), longint'(got.last_of_run)};
    w = '{longint'(want.out_ax), longint'(want.out_ay), longint'(want.out_az),
          longint'(want.out_bx), longint'(want.out_by), longint'(want.out_bz),
          longint'(want.out_cx), longint'(want.out_cy), longint'(want.out_cz),
          longint'(want.is_split), longint'(want.last_of_run)};
    for (int i = 0; i < 11; i++) begin
      if (g[i] != w[i]) begin
        $display("%0t: %s expected %0d actual %0d", $time, names[i], w[i], g[i]);
        errors++;
      end
    end
  endtask

  // Mostly clustered vertices with a spread biased small, so both outcomes show
  function automatic in_item_t rand_triangle();
    coord_t base[3];
    coord_t v[9];
    int     s;
    bit     wide;
    wide = ($urandom_range(0, 3) == 0);
    s = $urandom_range(0, $urandom_range(0, 22));
    for (int i = 0; i < 3; i++) begin
      base[i] = coord_t'($urandom);
    end
    for (int i = 0; i < 9; i++) begin
      if (wide) begin
        v[i] = coord_t'($urandom);
      end else begin
        v[i] = coord_t'(longint'(base[i % 3]) + longint'($urandom_range(0, 2 << s)) -
                        (longint'(1) << s));
      end
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
  endfunction

  function automatic in_item_t tri_of(vtx_t a, vtx_t b, vtx_t c);
    return {a, b, c};
  endfunction

  // Monitor: log accepted triangles and check popped results
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      in_acc <= rst_ni && push && !full;
      if (rst_ni) begin
        if (push && !full) begin
          predict_split(in_data_i);
        end
        if (pop && !empty) begin
          if (expected_tris.size() == 0) begin
            $display("%0t: result expected none actual %h", $time, res_data_o);
            errors++;
          end else begin
            check_tri(res_data_o, expected_tris.pop_front());
          end
        end
      end
    end
  end

  // Driver: advance on acceptance, insert random gaps after some items
  always @(negedge clk_i) begin
    if (in_acc) begin
      void'(tris_to_send.pop_front());
      if (!steady && $urandom_range(0, 4) == 0) begin
        tx_gap = $urandom_range(1, 15);
      end
    end
    if (tx_gap > 0 && !steady) begin
      tx_gap--;
      push <= 1'b0;
    end else if (tris_to_send.size() != 0) begin
      push      <= 1'b1;
      in_data_i <= tris_to_send[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Result side: pop with random stall bursts
  always @(negedge clk_i) begin
    if (rx_gap > 0 && !steady) begin
      rx_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!steady && $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(1, 15);
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tris_to_send.size() != 0 || expected_tris.size() != 0 || push);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THRESH_BITS-1:0] level);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= level;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    short_limit = level;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input logic [THRESH_BITS-1:0] level, input int n);
    write_threshold(level);
    repeat (n) add_item(rand_triangle());
    wait_drained();
  endtask

  initial begin
    vtx_t o;
    o = '0;
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners at the reset threshold
    add_item(tri_of(o, o, o));
    add_item(tri_of({CMIN, CMIN, CMIN}, {CMIN, CMIN, CMIN}, {CMIN, CMIN, CMIN}));
    add_item(tri_of({CMAX, CMAX, CMAX}, {CMAX, CMAX, CMAX}, {CMAX, CMAX, CMAX}));
    add_item(tri_of({CMIN, CMIN, CMIN}, {CMAX, CMAX, CMAX}, {CMIN, CMIN, CMIN}));
    add_item(tri_of({CMAX, CMAX, CMAX}, {CMIN, CMIN, CMIN}, {CMAX, CMAX, CMAX}));
    add_item(tri_of({CMIN, CMAX, CMIN}, {CMAX, CMIN, CMAX}, o));
    // One edge exactly at the limit splits; just below stays final
    add_item(tri_of(o, {24'sd16, 24'sd0, 24'sd0}, o));
    add_item(tri_of(o, {24'sd15, 24'sd0, 24'sd0}, o));
    add_item(tri_of(o, o, {24'sd0, 24'sd0, 24'sd16}));
    add_item(tri_of(o, {24'sd8, 24'sd0, 24'sd0}, {-24'sd8, 24'sd0, 24'sd0}));
    add_item(tri_of(o, {24'sd0, 24'sd9, 24'sd0}, {24'sd0, 24'sd0, 24'sd9}));
    add_item(tri_of({-24'sd1, -24'sd1, 24'sd0}, {24'sd0, -24'sd1, 24'sd0},
                    {-24'sd1, 24'sd0, -24'sd1}));
    // Odd sums: midpoints round toward minus infinity
    add_item(tri_of({-24'sd101, -24'sd33, 24'sd55}, {24'sd0, -24'sd2, -24'sd44},
                    {-24'sd7, 24'sd33, 24'sd1}));
    add_item(tri_of({CMAX, CMAX, CMAX}, {CMAX - 24'sd17, CMAX - 24'sd1, CMAX},
                    {CMAX, CMAX - 24'sd33, CMAX - 24'sd5}));
    add_item(tri_of({CMIN, CMIN, CMIN}, {CMIN + 24'sd17, CMIN + 24'sd1, CMIN},
                    {CMIN, CMIN + 24'sd33, CMIN + 24'sd5}));
    repeat (5) add_item(rand_triangle());
    wait_drained();

    random_phase('0, 15);
    random_phase(ThreshMax, 15);
    random_phase(THRESH_BITS'(1), 15);
    random_phase(THRESH_BITS'(1) << 30, 15);
    random_phase(THRESH_BITS'({$urandom, $urandom}) >> $urandom_range(0, 47), 15);
    steady = 1'b1;
    random_phase(ThreshReset, 15);

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
